### design/tprg_pkg.sv
// ----------------------------------------------------------------------------
// tprg_pkg
// Shared types and constants of the test pattern run generator: line region
// codes, raster geometry, palette and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tprg_pkg;

	// raster geometry
	localparam logic [8:0] GUARD_ROWS      = 9'd4;
	localparam logic [8:0] INSET_ROWS      = 9'd12;
	localparam logic [8:0] BOTTOM_GUARD_Y  = 9'd476;
	localparam logic [8:0] BOTTOM_INSET_Y  = 9'd468;
	localparam logic [8:0] RAMP_Y          = 9'd320;
	localparam logic [8:0] GREEN_Y         = 9'd352;
	localparam logic [8:0] BLUE_Y          = 9'd384;
	localparam logic [8:0] CHECK_Y         = 9'd416;

	// run lengths
	localparam logic [9:0] LEN_LINE        = 10'd640;
	localparam logic [9:0] LEN_GUARD       = 10'd4;
	localparam logic [9:0] LEN_BORDER      = 10'd8;
	localparam logic [9:0] LEN_WIDE_BORDER = 10'd632;
	localparam logic [9:0] LEN_BAR         = 10'd77;
	localparam logic [9:0] LEN_RAMP_EVEN   = 10'd39;
	localparam logic [9:0] LEN_RAMP_ODD    = 10'd38;
	localparam logic [9:0] LEN_SQUARE      = 10'd16;
	localparam logic [9:0] LEN_TAIL        = 10'd8;

	// colors, rgb444 with red in the low nibble
	localparam logic [11:0] RGB_BLACK  = 12'h000;
	localparam logic [11:0] RGB_BORDER = 12'hf0f;
	localparam logic [11:0] RGB_WHITE  = 12'hfff;

	// buffer capacity
	localparam logic [7:0] MIN_WORDS        = 8'd65;
	localparam logic [7:0] BUF_WORDS_RESET  = 8'd65;

	// index of the checkerboard tail run within the content
	localparam logic [5:0] CHECK_TAIL_IDX = 6'd38;

	// line region codes
	localparam logic [2:0] REG_BLANK  = 3'd0;
	localparam logic [2:0] REG_BORDER = 3'd1;
	localparam logic [2:0] REG_BARS   = 3'd2;
	localparam logic [2:0] REG_RAMP   = 3'd3;
	localparam logic [2:0] REG_CHECK  = 3'd4;
	localparam logic [2:0] REG_ERROR  = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic emit;
	} tprg_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last;
	} tprg_stat_t;

	// color bar palette
	function automatic logic [11:0] bar_rgb(input logic [2:0] idx);
		logic [11:0] c;
		unique case (idx)
			3'd0:    c = 12'hfff;
			3'd1:    c = 12'h0ff;
			3'd2:    c = 12'hff0;
			3'd3:    c = 12'h0f0;
			3'd4:    c = 12'hf0f;
			3'd5:    c = 12'h00f;
			3'd6:    c = 12'hf00;
			default: c = 12'h000;
		endcase
		return c;
	endfunction

endpackage

### design/test_pattern_run_generator.sv
// ----------------------------------------------------------------------------
// test_pattern_run_generator
// Turns a 640x480 line number into that line's test pattern as color runs.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  line_number
//   out      output     out_valid/out_stall  run_color, run_length,
//                                            line_last, align_kind,
//                                            words_used, line_error
//   cfg      input      cfg_we               cfg_wdata (buffer_words)
//
// The line word is taken first, then one run per cycle while out_stall allows,
// from the run index counter in the datapath (43 runs per line at most).
// Reset sets buffer_words to 65 and leaves no words pending.
// out_stall holds the output register and pauses the run counter; the input
// is stalled while a line is being emitted.
// ----------------------------------------------------------------------------
module test_pattern_run_generator
	import tprg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [8:0]  line_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] run_color,
	output logic [9:0]  run_length,
	output logic        line_last,
	output logic        align_kind,
	output logic [6:0]  words_used,
	output logic        line_error,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	tprg_cmd_t  cmd;
	tprg_stat_t stat;
	logic [7:0] buffer_words_q;

	// buffer capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_words_q <= BUF_WORDS_RESET;
		end else if (cfg_we) begin
			buffer_words_q <= cfg_wdata;
		end
	end

	// controller
	tprg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath
	tprg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.line_number  (line_number),
		.buffer_words (buffer_words_q),
		.run_color    (run_color),
		.run_length   (run_length),
		.line_last    (line_last),
		.align_kind   (align_kind),
		.words_used   (words_used),
		.line_error   (line_error)
	);

endmodule

### design/tprg_ctrl.sv
// ----------------------------------------------------------------------------
// tprg_ctrl
// Controller: takes a line word, then steps the datapath one run per cycle
// into the output register while that register is free.
// ----------------------------------------------------------------------------
module tprg_ctrl
	import tprg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output tprg_cmd_t  cmd,
	input  tprg_stat_t stat
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	// output register can take a new run
	assign out_free = !out_valid_q || !out_stall;

	// command decode
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.emit = (state_q == ST_RUN) && out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cmd.emit && stat.last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/tprg_dp.sv
// ----------------------------------------------------------------------------
// tprg_dp
// Datapath: latches the line and its region, keeps the run index and builds
// each run's color, length and end-of-line fields into the output register.
// ----------------------------------------------------------------------------
module tprg_dp
	import tprg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tprg_cmd_t   cmd,
	output tprg_stat_t  stat,
	input  logic [8:0]  line_number,
	input  logic [7:0]  buffer_words,
	output logic [11:0] run_color,
	output logic [9:0]  run_length,
	output logic        line_last,
	output logic        align_kind,
	output logic [6:0]  words_used,
	output logic        line_error
);

	logic [8:0]  line_q;
	logic [2:0]  region_q;
	logic [5:0]  idx_q;
	logic [2:0]  region_d;

	logic [11:0] color_d;
	logic [9:0]  len_d;
	logic [5:0]  cnt;
	logic [6:0]  words_d;
	logic        align_d;
	logic        last_d;
	logic [5:0]  k;
	logic [8:0]  check_row;

	logic [11:0] color_q;
	logic [9:0]  len_q;
	logic        last_q;
	logic        align_q;
	logic [6:0]  words_q;
	logic        err_q;

	// region of the incoming line
	always_comb begin
		if (buffer_words < MIN_WORDS) begin
			region_d = REG_ERROR;
		end else if (line_number < GUARD_ROWS || line_number >= BOTTOM_GUARD_Y) begin
			region_d = REG_BLANK;
		end else if (line_number < INSET_ROWS || line_number >= BOTTOM_INSET_Y) begin
			region_d = REG_BORDER;
		end else if (line_number < RAMP_Y) begin
			region_d = REG_BARS;
		end else if (line_number < CHECK_Y) begin
			region_d = REG_RAMP;
		end else begin
			region_d = REG_CHECK;
		end
	end

	// line, region and run index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			region_q <= REG_BLANK;
		end else if (cmd.load) begin
			idx_q    <= '0;
			region_q <= region_d;
		end else if (cmd.emit) begin
			idx_q    <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) line_q <= line_number;
	end

	// run count and line close per region
	always_comb begin
		unique case (region_q)
			REG_BLANK:  begin cnt = 6'd1;  words_d = 7'd2;  align_d = 1'b0; end
			REG_BORDER: begin cnt = 6'd3;  words_d = 7'd5;  align_d = 1'b0; end
			REG_BARS:   begin cnt = 6'd12; words_d = 7'd19; align_d = 1'b1; end
			REG_RAMP:   begin cnt = 6'd20; words_d = 7'd31; align_d = 1'b1; end
			REG_CHECK:  begin cnt = 6'd43; words_d = 7'd65; align_d = 1'b0; end
			default:    begin cnt = 6'd1;  words_d = 7'd0;  align_d = 1'b0; end
		endcase
	end

	assign last_d    = (idx_q == cnt - 6'd1);
	assign stat.last = last_d;
	assign k         = idx_q - 6'd2;
	assign check_row = line_q - CHECK_Y;

	// current run
	always_comb begin
		color_d = RGB_BLACK;
		len_d   = LEN_GUARD;
		unique case (region_q) inside
			REG_BLANK: begin
				len_d = LEN_LINE;
			end
			REG_BORDER: begin
				if (idx_q == 6'd1) begin
					color_d = RGB_BORDER;
					len_d   = LEN_WIDE_BORDER;
				end
			end
			REG_BARS, REG_RAMP, REG_CHECK: begin
				if (idx_q == 6'd0 || idx_q == cnt - 6'd1) begin
					color_d = RGB_BLACK;
					len_d   = LEN_GUARD;
				end else if (idx_q == 6'd1 || idx_q == cnt - 6'd2) begin
					color_d = RGB_BORDER;
					len_d   = LEN_BORDER;
				end else if (region_q == REG_BARS) begin
					color_d = bar_rgb(k[2:0]);
					len_d   = LEN_BAR;
				end else if (region_q == REG_RAMP) begin
					len_d = k[0] ? LEN_RAMP_ODD : LEN_RAMP_EVEN;
					if (line_q < GREEN_Y)      color_d = {8'h00, k[3:0]};
					else if (line_q < BLUE_Y)  color_d = {4'h0, k[3:0], 4'h0};
					else                       color_d = {k[3:0], 8'h00};
				end else begin
					color_d = (k[0] ^ check_row[4]) ? RGB_WHITE : RGB_BLACK;
					len_d   = (k == CHECK_TAIL_IDX) ? LEN_TAIL : LEN_SQUARE;
				end
			end
			default: begin
				color_d = RGB_BLACK;
				len_d   = '0;
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			color_q <= color_d;
			len_q   <= len_d;
			last_q  <= last_d;
			align_q <= last_d ? align_d : 1'b0;
			words_q <= last_d ? words_d : 7'd0;
			err_q   <= (region_q == REG_ERROR);
		end
	end

	assign run_color  = color_q;
	assign run_length = len_q;
	assign line_last  = last_q;
	assign align_kind = align_q;
	assign words_used = words_q;
	assign line_error = err_q;

endmodule
